// ----- hw/rtl/quadratic_feature_lift_top_assert.svh -----
// assertion macros shared by the quadratic feature lift rtl
`ifndef QUADRATIC_FEATURE_LIFT_TOP_ASSERT_SVH
`define QUADRATIC_FEATURE_LIFT_TOP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define QFL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qfl assertion failed");

// next-cycle implication, disabled while in reset
`define QFL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qfl assertion failed");

`endif

// ----- hw/rtl/qfl_pkg.sv -----
// shared constants, types and helpers of the quadratic feature lift
package qfl_pkg;

    localparam int MAX_DIM    = 8;
    localparam int ADDR_W     = $clog2(MAX_DIM);
    localparam int DIM_W      = 4;
    localparam int COORD_W    = 16;
    localparam int FEAT_W     = 37;
    localparam int POS_W      = 6;
    localparam int NORM_W     = 46;
    localparam int NFEAT_MAX  = MAX_DIM * (MAX_DIM + 1) / 2;
    localparam int MUL_W      = 34;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int NUM_W      = 105;
    localparam int DEN_W      = 64;
    localparam int QUO_W      = 62;
    localparam int DIV_FRAC   = 16;
    localparam int ROOT_W     = 32;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 96;

    typedef struct packed {
        logic busy;
        logic done;
    } t_root_stat;

    // number of lifted features for d coordinates
    function automatic logic [POS_W-1:0] nfeat(input logic [DIM_W-1:0] d);
        logic [7:0] p;
        p = {4'b0, d} * ({4'b0, d} + 8'd1);
        return POS_W'(p >> 1);
    endfunction

endpackage

// ----- hw/rtl/qfl_mul.sv -----
// shared unsigned multiplier with registered product
module qfl_mul (
    input  logic                        i_clk,
    input  logic                        i_go,
    input  logic [qfl_pkg::MUL_W-1:0]   i_a,
    input  logic [qfl_pkg::MUL_W-1:0]   i_b,
    output logic [qfl_pkg::PROD_W-1:0]  o_prod
);
    import qfl_pkg::*;

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
        end
    end

    assign o_prod = r_prod;

endmodule

// ----- hw/rtl/qfl_root.sv -----
// iterative floor divide followed by floor square root, one bit per cycle
module qfl_root (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [qfl_pkg::NUM_W-1:0]   i_num,
    input  logic [qfl_pkg::DEN_W-1:0]   i_den,
    output logic [qfl_pkg::ROOT_W-1:0]  o_root,
    output qfl_pkg::t_root_stat         o_stat
);
    import qfl_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_DIV  = 2'd1;
    localparam logic [1:0] PH_SQRT = 2'd2;

    logic [1:0]        r_phase;
    logic [5:0]        r_cnt;
    logic              r_done;
    logic [DEN_W-1:0]  r_rem;
    logic [QUO_W-1:0]  r_dvd;
    logic [QUO_W-1:0]  r_quo;
    logic [QUO_W-1:0]  r_val;
    logic [QUO_W-1:0]  r_res;
    logic [QUO_W-1:0]  r_bit;
    logic [ROOT_W-1:0] r_root;

    logic [DEN_W:0]    sh;
    logic [DEN_W:0]    diff;
    logic              ge;
    logic [DEN_W-1:0]  n_rem;
    logic [QUO_W-1:0]  n_quo;
    logic [QUO_W-1:0]  sq_t;
    logic              sq_ge;
    logic [QUO_W-1:0]  n_res;
    logic [QUO_W-1:0]  n_val;

    // restoring division step
    always_comb begin
        sh    = {r_rem, r_dvd[QUO_W-1]};
        diff  = sh - {1'b0, i_den};
        ge    = sh >= {1'b0, i_den};
        n_rem = ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
        n_quo = {r_quo[QUO_W-2:0], ge};
    end

    // bit-pair square root step
    always_comb begin
        sq_t  = r_res + r_bit;
        sq_ge = r_val >= sq_t;
        n_res = sq_ge ? (r_res >> 1) + r_bit : r_res >> 1;
        n_val = sq_ge ? r_val - sq_t : r_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_phase)
                PH_IDLE: begin
                    if (i_start) begin
                        r_phase <= PH_DIV;
                        r_cnt   <= 6'(QUO_W - 1);
                    end
                end
                PH_DIV: begin
                    if (r_cnt == '0) begin
                        r_phase <= PH_SQRT;
                        r_cnt   <= 6'(QUO_W / 2 - 1);
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                PH_SQRT: begin
                    if (r_cnt == '0) begin
                        r_phase <= PH_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                default: begin
                    r_phase <= PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_phase)
            PH_IDLE: begin
                if (i_start) begin
                    // quotient fits QUO_W bits, so the top bits seed the remainder
                    r_rem <= DEN_W'(i_num >> (QUO_W - DIV_FRAC));
                    r_dvd <= {i_num[QUO_W-DIV_FRAC-1:0], {DIV_FRAC{1'b0}}};
                    r_quo <= '0;
                end
            end
            PH_DIV: begin
                r_rem <= n_rem;
                r_dvd <= r_dvd << 1;
                r_quo <= n_quo;
                if (r_cnt == '0) begin
                    r_val <= n_quo;
                    r_res <= '0;
                    r_bit <= QUO_W'(1) << (QUO_W - 2);
                end
            end
            PH_SQRT: begin
                r_val <= n_val;
                r_res <= n_res;
                r_bit <= r_bit >> 2;
                if (r_cnt == '0) begin
                    r_root <= n_res[ROOT_W-1:0];
                end
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

    assign o_root      = r_root;
    assign o_stat.busy = r_phase != PH_IDLE;
    assign o_stat.done = r_done;

endmodule

// ----- hw/rtl/quadratic_feature_lift_top.sv -----
// top level of the quadratic feature lift: sequencer, coordinate store, output register
//
// Collects one vector of dim_in_use signed Q1.15 coordinates, one per input
// transaction, and then emits its quadratic lift as Q8.28 features: the squares
// first, then the pairwise products in row order. The vector's work runs on one
// shared 34x34 multiplier and, for a query, one bit-serial divide and square root
// unit, and no input is taken until the last feature (for a query, the trailing
// zero) has been handed to the output register. A data vector first computes its
// lifted norm and then its features. A query first sums its norm and then, for
// each feature, fetches and multiplies, divides and takes the square root; a
// degenerate query skips the divide and root. Output back-pressure can stall
// each hand-over to the output register.
// tdata of the output carries feature, position and lifted norm; tuser carries
// the degenerate flag; tlast marks the last feature of a data vector and the
// trailing zero of a query.
`include "quadratic_feature_lift_top_assert.svh"

module quadratic_feature_lift_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // register write: dim_in_use
    input  logic                              i_cfg_wen,
    input  logic [qfl_pkg::DIM_W-1:0]         i_cfg_wdata,
    // input stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [qfl_pkg::IN_DATA_W-1:0]     i_s_tdata,   // coord[15:0]
    input  logic                              i_s_tuser,   // kind
    // output stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [qfl_pkg::OUT_DATA_W-1:0]    o_m_tdata,   // feature[36:0], position[42:37],
                                                           // lifted_norm[88:43], zero pad
    output logic                              o_m_tlast,   // last
    output logic                              o_m_tuser    // degenerate
);
    import qfl_pkg::*;

    // sequencer states
    localparam logic [4:0] ST_COLLECT = 5'd0;
    localparam logic [4:0] ST_FI      = 5'd1;
    localparam logic [4:0] ST_FJ      = 5'd2;
    localparam logic [4:0] ST_MUL     = 5'd3;
    localparam logic [4:0] ST_N1      = 5'd4;
    localparam logic [4:0] ST_N2      = 5'd5;
    localparam logic [4:0] ST_N3      = 5'd6;
    localparam logic [4:0] ST_N4      = 5'd7;
    localparam logic [4:0] ST_N5      = 5'd8;
    localparam logic [4:0] ST_DW      = 5'd9;
    localparam logic [4:0] ST_Q1      = 5'd10;
    localparam logic [4:0] ST_Q2      = 5'd11;
    localparam logic [4:0] ST_G1      = 5'd12;
    localparam logic [4:0] ST_G2      = 5'd13;
    localparam logic [4:0] ST_P0      = 5'd14;
    localparam logic [4:0] ST_P1      = 5'd15;
    localparam logic [4:0] ST_P2      = 5'd16;
    localparam logic [4:0] ST_P3      = 5'd17;
    localparam logic [4:0] ST_P4      = 5'd18;
    localparam logic [4:0] ST_RS      = 5'd19;
    localparam logic [4:0] ST_RW      = 5'd20;
    localparam logic [4:0] ST_EMIT    = 5'd21;
    localparam logic [4:0] ST_TAIL    = 5'd22;

    // what the feature walk is doing
    localparam logic [1:0] PH_NORM = 2'd0;
    localparam logic [1:0] PH_DATA = 2'd1;
    localparam logic [1:0] PH_QSUM = 2'd2;
    localparam logic [1:0] PH_QOUT = 2'd3;

    localparam logic [NORM_W-1:0] NORM_SAT = {NORM_W{1'b1}};

    logic [4:0]          r_state;
    logic [1:0]          r_phase;
    logic [DIM_W-1:0]    r_dim;
    logic [ADDR_W-1:0]   r_count;
    logic                r_kind;
    logic [ADDR_W-1:0]   r_i;
    logic [ADDR_W-1:0]   r_j;
    logic                r_sq;
    logic [POS_W-1:0]    r_pos;

    logic [COORD_W-1:0]  r_mem [MAX_DIM];
    logic [COORD_W-1:0]  r_rdata;
    logic [COORD_W-1:0]  r_xi;
    logic                r_sgn;

    logic [MUL_W-1:0]    r_n2;
    logic [DEN_W-1:0]    r_n4;
    logic [NUM_W-1:0]    r_acc;
    logic [DEN_W-1:0]    r_q;
    logic [NORM_W-1:0]   r_norm;
    logic [NORM_W-1:0]   r_max;
    logic                r_degen;
    logic [58:0]         r_m2;
    logic                r_gneg;
    logic [ROOT_W-1:0]   r_fmag;
    logic                r_root_go;

    logic                r_ovalid;
    logic [FEAT_W-1:0]   r_ofeat;
    logic [POS_W-1:0]    r_opos;
    logic                r_olast;
    logic [NORM_W-1:0]   r_onorm;
    logic                r_odegen;

    logic [DIM_W-1:0]    d_use;
    logic [ADDR_W-1:0]   dm1;
    logic [POS_W-1:0]    nf;
    logic                is_last;
    logic                s_acc;
    logic                last_coord;
    logic                kind_now;
    logic [ADDR_W-1:0]   rd_addr;
    logic                out_free;

    logic [ADDR_W-1:0]   n_i;
    logic [ADDR_W-1:0]   n_j;
    logic                n_sq;

    logic [MUL_W-1:0]    mul_a;
    logic [MUL_W-1:0]    mul_b;
    logic                mul_go;
    logic [PROD_W-1:0]   prod;

    logic [COORD_W-1:0]  mag_i;
    logic [COORD_W-1:0]  mag_j;
    logic signed [34:0]  pe;
    logic signed [34:0]  dsum;
    logic signed [34:0]  dsh;
    logic [FEAT_W-1:0]   dfeat;
    logic signed [34:0]  gval;
    logic signed [34:0]  gsum;
    logic signed [34:0]  gr;
    logic signed [34:0]  gabs;
    logic [29:0]         gmag;
    logic [DEN_W-1:0]    n_q;
    logic [68:0]         nsum;
    logic [47:0]         nshift;
    logic [NORM_W-1:0]   nsat;
    logic [ROOT_W:0]     qf_neg;
    logic [FEAT_W-1:0]   qfeat;

    logic [ROOT_W-1:0]   root;
    t_root_stat          root_stat;

    // dimension in force, clamped to 1..MAX_DIM
    always_comb begin
        if (r_dim == '0) begin
            d_use = DIM_W'(1);
        end else if (r_dim > DIM_W'(MAX_DIM)) begin
            d_use = DIM_W'(MAX_DIM);
        end else begin
            d_use = r_dim;
        end
        dm1 = ADDR_W'(d_use - DIM_W'(1));
        nf  = nfeat(d_use);
    end

    assign is_last    = r_pos == nf - POS_W'(1);
    assign o_s_tready = r_state == ST_COLLECT;
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign last_coord = (DIM_W'(r_count) + DIM_W'(1)) >= d_use;
    assign kind_now   = (r_count == '0) ? i_s_tuser : r_kind;
    assign out_free   = !r_ovalid || i_m_tready;
    assign rd_addr    = (r_state == ST_FJ) ? r_j : r_i;

    // walk order: squares, then pairs (i, j) with i < j
    always_comb begin
        n_i  = r_i;
        n_j  = r_j;
        n_sq = r_sq;
        if (r_sq) begin
            if (r_i == dm1) begin
                n_i  = '0;
                n_j  = ADDR_W'(1);
                n_sq = 1'b0;
            end else begin
                n_i = r_i + ADDR_W'(1);
                n_j = r_i + ADDR_W'(1);
            end
        end else if (r_j == dm1) begin
            n_i = r_i + ADDR_W'(1);
            n_j = r_i + ADDR_W'(2);
        end else begin
            n_j = r_j + ADDR_W'(1);
        end
    end

    // coordinate product to features
    always_comb begin
        mag_i = r_xi[COORD_W-1] ? COORD_W'(-r_xi) : r_xi;
        mag_j = r_rdata[COORD_W-1] ? COORD_W'(-r_rdata) : r_rdata;
        pe    = r_sgn ? -$signed({4'b0, prod[30:0]}) : $signed({4'b0, prod[30:0]});
        // round to Q8.28, half up
        dsum  = pe + 35'sd2;
        dsh   = dsum >>> 2;
        dfeat = {{2{dsh[34]}}, dsh};
        // unscaled query feature: minus square, or minus twice the product
        gval  = r_sq ? -pe : -(pe <<< 1);
        gsum  = gval + 35'sd2;
        gr    = gsum >>> 2;
        gabs  = gr[34] ? -gr : gr;
        gmag  = gabs[29:0];
        n_q   = r_q + prod[DEN_W-1:0];
        // lifted norm: (n2^2 + n4 + half lsb) scaled down, saturating
        nshift = r_acc[68:21];
        nsat   = (nshift > {2'b0, NORM_SAT}) ? NORM_SAT : nshift[NORM_W-1:0];
        nsum   = {1'b0, prod} + 69'(r_n4) + (69'(1) << 20);
        qf_neg = -{1'b0, r_fmag};
        qfeat  = r_gneg ? {{(FEAT_W-ROOT_W-1){qf_neg[ROOT_W]}}, qf_neg}
                        : FEAT_W'(r_fmag);
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_go = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        case (r_state)
            ST_MUL: begin
                mul_go = 1'b1;
                mul_a  = MUL_W'(mag_i);
                mul_b  = MUL_W'(mag_j);
            end
            ST_N1: begin
                mul_go = 1'b1;
                mul_a  = prod[MUL_W-1:0];
                mul_b  = prod[MUL_W-1:0];
            end
            ST_N3: begin
                mul_go = 1'b1;
                mul_a  = r_n2;
                mul_b  = r_n2;
            end
            ST_Q1, ST_G1: begin
                mul_go = 1'b1;
                mul_a  = MUL_W'(gmag);
                mul_b  = MUL_W'(gmag);
            end
            ST_P0: begin
                mul_go = 1'b1;
                mul_a  = MUL_W'(r_m2[31:0]);
                mul_b  = MUL_W'(r_max[31:0]);
            end
            ST_P1: begin
                mul_go = 1'b1;
                mul_a  = MUL_W'(r_m2[31:0]);
                mul_b  = MUL_W'(r_max[NORM_W-1:32]);
            end
            ST_P2: begin
                mul_go = 1'b1;
                mul_a  = MUL_W'(r_m2[58:32]);
                mul_b  = MUL_W'(r_max[31:0]);
            end
            ST_P3: begin
                mul_go = 1'b1;
                mul_a  = MUL_W'(r_m2[58:32]);
                mul_b  = MUL_W'(r_max[NORM_W-1:32]);
            end
            default: begin
                mul_go = 1'b0;
            end
        endcase
    end

    qfl_mul u_mul (
        .i_clk  (i_clk),
        .i_go   (mul_go),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    qfl_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_root_go),
        .i_num   (r_acc),
        .i_den   (r_q),
        .o_root  (root),
        .o_stat  (root_stat)
    );

    // coordinate store, registered read
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_mem[r_count] <= i_s_tdata;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_COLLECT;
            r_phase   <= PH_NORM;
            r_dim     <= DIM_W'(MAX_DIM);
            r_count   <= '0;
            r_kind    <= 1'b0;
            r_i       <= '0;
            r_j       <= '0;
            r_sq      <= 1'b1;
            r_pos     <= '0;
            r_max     <= '0;
            r_degen   <= 1'b0;
            r_root_go <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_root_go <= 1'b0;
            if (i_cfg_wen) begin
                r_dim <= i_cfg_wdata;
            end
            if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_COLLECT: begin
                    if (s_acc) begin
                        r_kind <= kind_now;
                        if (last_coord) begin
                            r_count <= '0;
                            r_i     <= '0;
                            r_j     <= '0;
                            r_sq    <= 1'b1;
                            r_pos   <= '0;
                            r_n2    <= '0;
                            r_n4    <= '0;
                            r_q     <= '0;
                            r_phase <= kind_now ? PH_QSUM : PH_NORM;
                            r_state <= ST_FI;
                        end else begin
                            r_count <= r_count + ADDR_W'(1);
                        end
                    end
                end
                ST_FI: begin
                    r_state <= ST_FJ;
                end
                ST_FJ: begin
                    r_xi    <= r_rdata;
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_sgn <= r_xi[COORD_W-1] ^ r_rdata[COORD_W-1];
                    case (r_phase)
                        PH_NORM: r_state <= ST_N1;
                        PH_DATA: r_state <= ST_DW;
                        PH_QSUM: r_state <= ST_Q1;
                        default: r_state <= ST_G1;
                    endcase
                end
                ST_N1: begin
                    r_n2    <= r_n2 + prod[MUL_W-1:0];
                    r_state <= ST_N2;
                end
                ST_N2: begin
                    r_n4 <= r_n4 + prod[DEN_W-1:0];
                    if (r_i == dm1) begin
                        r_state <= ST_N3;
                    end else begin
                        r_i     <= r_i + ADDR_W'(1);
                        r_j     <= r_i + ADDR_W'(1);
                        r_state <= ST_FI;
                    end
                end
                ST_N3: begin
                    r_state <= ST_N4;
                end
                ST_N4: begin
                    r_acc   <= NUM_W'(nsum);
                    r_state <= ST_N5;
                end
                ST_N5: begin
                    r_norm <= nsat;
                    if (nsat > r_max) begin
                        r_max <= nsat;
                    end
                    r_i     <= '0;
                    r_j     <= '0;
                    r_sq    <= 1'b1;
                    r_pos   <= '0;
                    r_phase <= PH_DATA;
                    r_state <= ST_FI;
                end
                ST_DW: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_ofeat  <= dfeat;
                        r_opos   <= r_pos;
                        r_olast  <= is_last;
                        r_onorm  <= r_norm;
                        r_odegen <= 1'b0;
                        if (is_last) begin
                            r_state <= ST_COLLECT;
                        end else begin
                            r_i     <= n_i;
                            r_j     <= n_j;
                            r_sq    <= n_sq;
                            r_pos   <= r_pos + POS_W'(1);
                            r_state <= ST_FI;
                        end
                    end
                end
                ST_Q1: begin
                    r_state <= ST_Q2;
                end
                ST_Q2: begin
                    r_q <= n_q;
                    if (is_last) begin
                        r_degen <= n_q == '0;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_sq    <= 1'b1;
                        r_pos   <= '0;
                        r_phase <= PH_QOUT;
                    end else begin
                        r_i   <= n_i;
                        r_j   <= n_j;
                        r_sq  <= n_sq;
                        r_pos <= r_pos + POS_W'(1);
                    end
                    r_state <= ST_FI;
                end
                ST_G1: begin
                    r_gneg <= gr[34];
                    if (r_degen) begin
                        r_fmag  <= '0;
                        r_state <= ST_EMIT;
                    end else begin
                        r_state <= ST_G2;
                    end
                end
                ST_G2: begin
                    r_m2    <= prod[58:0];
                    r_state <= ST_P0;
                end
                ST_P0: begin
                    r_state <= ST_P1;
                end
                ST_P1: begin
                    r_acc   <= NUM_W'(prod);
                    r_state <= ST_P2;
                end
                ST_P2: begin
                    r_acc   <= r_acc + (NUM_W'(prod) << 32);
                    r_state <= ST_P3;
                end
                ST_P3: begin
                    r_acc   <= r_acc + (NUM_W'(prod) << 32);
                    r_state <= ST_P4;
                end
                ST_P4: begin
                    r_acc   <= r_acc + (NUM_W'(prod) << 64);
                    r_state <= ST_RS;
                end
                ST_RS: begin
                    r_root_go <= 1'b1;
                    r_state   <= ST_RW;
                end
                ST_RW: begin
                    if (root_stat.done) begin
                        r_fmag  <= root;
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_ofeat  <= qfeat;
                        r_opos   <= r_pos;
                        r_olast  <= 1'b0;
                        r_onorm  <= '0;
                        r_odegen <= r_degen;
                        if (is_last) begin
                            r_state <= ST_TAIL;
                        end else begin
                            r_i     <= n_i;
                            r_j     <= n_j;
                            r_sq    <= n_sq;
                            r_pos   <= r_pos + POS_W'(1);
                            r_state <= ST_FI;
                        end
                    end
                end
                ST_TAIL: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_ofeat  <= '0;
                        r_opos   <= nf;
                        r_olast  <= 1'b1;
                        r_onorm  <= '0;
                        r_odegen <= r_degen;
                        r_state  <= ST_COLLECT;
                    end
                end
                default: begin
                    r_state <= ST_COLLECT;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {{(OUT_DATA_W-FEAT_W-POS_W-NORM_W){1'b0}}, r_onorm, r_opos, r_ofeat};
    assign o_m_tlast  = r_olast;
    assign o_m_tuser  = r_odegen;

    // degenerate queries carry zero features and no norm
    `QFL_ASSERT_IMP(a_degen_zero, i_clk, i_rst_n, r_ovalid && r_odegen,
                    r_ofeat == '0 && r_onorm == '0)
    // running maximum never falls
    `QFL_ASSERT_NXT(a_max_mono, i_clk, i_rst_n, 1'b1, r_max >= $past(r_max))
    // while waiting for the root the unit is working or just finished
    `QFL_ASSERT_IMP(a_root_wait, i_clk, i_rst_n, r_state == ST_RW && !r_root_go,
                    root_stat.busy || root_stat.done)
    // positions stay inside the lifted vector plus the query tail
    `QFL_ASSERT_IMP(a_pos_range, i_clk, i_rst_n, r_ovalid, r_opos <= POS_W'(NFEAT_MAX))

endmodule
